/* rtl/ps2c_pkg.sv */
// ps2c_pkg: shared widths, reset values and codes for the PS/2 mouse text cursor.
// Used by ps2c_clamp and ps2_mouse_text_cursor; depends on nothing.
package ps2c_pkg;

  // Field widths
  localparam int COORD_W = 8;
  localparam int CELL_W  = 16;
  // Signed width of position plus or minus a 9-bit move
  localparam int SUM_W   = COORD_W + 3;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

  // Reset values
  localparam logic [COORD_W-1:0] RESET_COLUMNS = 8'd80;
  localparam logic [COORD_W-1:0] RESET_ROWS    = 8'd25;
  localparam logic [COORD_W-1:0] RESET_COLUMN  = 8'd40;
  localparam logic [COORD_W-1:0] RESET_ROW     = 8'd12;

  // Header sign bits
  localparam int SIGN_X_POS = 4;
  localparam int SIGN_Y_POS = 5;

  // Position of the next byte within a packet
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XMOVE  = 2'd1,
    PH_YMOVE  = 2'd2
  } phase_t;

endpackage

/* rtl/ps2_mouse_text_cursor.sv */
// ps2_mouse_text_cursor: groups PS/2 mouse bytes into packets and moves a text cursor.
// Depends on ps2c_pkg and ps2c_clamp.
//
//  channel | handshake                  | payload                                    | dir
//  --------+----------------------------+--------------------------------------------+----
//  byte    | byte_valid, byte_stall     | data_byte                                  | in
//  cursor  | cursor_valid, cursor_stall | erase_cell, draw_cell, new_column, new_row | out
//  config  | cfg_write                  | cfg_index, cfg_data                        | in
//
// One byte is taken every cycle unless byte_stall holds it. A third byte gives a result
// through the middle stage and the output register: the move, clamp and erase index are
// formed at the input, the draw index (one 8x8 multiply) between those two registers.
// Reset restores an 80x25 screen, cursor at column 40 row 12, packet phase 0.
// A stall on the cursor side holds the output; bytes keep flowing until the
// middle stage is full as well.
module ps2_mouse_text_cursor (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [ps2c_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ps2c_pkg::COORD_W-1:0]          cfg_data,
  input  logic                                  byte_valid,
  output logic                                  byte_stall,
  input  logic [7:0]                            data_byte,
  output logic                                  cursor_valid,
  input  logic                                  cursor_stall,
  output logic [ps2c_pkg::CELL_W-1:0]           erase_cell,
  output logic [ps2c_pkg::CELL_W-1:0]           draw_cell,
  output logic [ps2c_pkg::COORD_W-1:0]          new_column,
  output logic [ps2c_pkg::COORD_W-1:0]          new_row
);

  // row * columns + column, kept to 16 bits
  function automatic logic [ps2c_pkg::CELL_W-1:0] cell_of(
    input logic [ps2c_pkg::COORD_W-1:0] r,
    input logic [ps2c_pkg::COORD_W-1:0] c,
    input logic [ps2c_pkg::COORD_W-1:0] cols
  );
    logic [ps2c_pkg::CELL_W-1:0] prod;
    prod = {8'd0, r} * {8'd0, cols};
    return prod + {8'd0, c};
  endfunction

  logic [ps2c_pkg::COORD_W-1:0] screen_columns;
  logic [ps2c_pkg::COORD_W-1:0] screen_rows;

  ps2c_pkg::phase_t byte_phase, byte_phase_next;
  logic [7:0] header_byte;
  logic [7:0] x_move_byte;
  logic [ps2c_pkg::COORD_W-1:0] column_now;
  logic [ps2c_pkg::COORD_W-1:0] row_now;

  logic                         s1_valid;
  logic [ps2c_pkg::COORD_W-1:0] s1_col;
  logic [ps2c_pkg::COORD_W-1:0] s1_row;
  logic [ps2c_pkg::CELL_W-1:0]  s1_erase;

  logic byte_take;
  logic packet_done;
  logic s1_move;
  logic sign_x, sign_y;
  logic signed [ps2c_pkg::SUM_W-1:0] col_sum, row_sum;
  logic [ps2c_pkg::COORD_W-1:0] col_clamped, row_clamped;

  // Handshake: middle stage drains into the output when that is empty or taken
  assign s1_move    = s1_valid && (!cursor_valid || !cursor_stall);
  assign byte_stall = s1_valid && !s1_move;
  assign byte_take  = byte_valid && !byte_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= ps2c_pkg::RESET_COLUMNS;
      screen_rows    <= ps2c_pkg::RESET_ROWS;
    end else if (cfg_write) begin
      if (cfg_index == ps2c_pkg::CFG_COLUMNS) screen_columns <= cfg_data;
      if (cfg_index == ps2c_pkg::CFG_ROWS)    screen_rows    <= cfg_data;
    end
  end

  // Packet phase: third byte (and the unused fourth code) completes a packet
  always_comb begin
    byte_phase_next = byte_phase;
    packet_done     = 1'b0;
    if (byte_take) begin
      case (byte_phase)
        ps2c_pkg::PH_HEADER: byte_phase_next = ps2c_pkg::PH_XMOVE;
        ps2c_pkg::PH_XMOVE:  byte_phase_next = ps2c_pkg::PH_YMOVE;
        default: begin
          byte_phase_next = ps2c_pkg::PH_HEADER;
          packet_done     = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= ps2c_pkg::PH_HEADER;
    end else begin
      byte_phase <= byte_phase_next;
    end
  end

  // Move values: 9-bit two's complement, sign from the header
  assign sign_x  = header_byte[ps2c_pkg::SIGN_X_POS];
  assign sign_y  = header_byte[ps2c_pkg::SIGN_Y_POS];
  assign col_sum = $signed({3'b000, column_now}) + $signed({{3{sign_x}}, x_move_byte});
  assign row_sum = $signed({3'b000, row_now}) - $signed({{3{sign_y}}, data_byte});

  ps2c_clamp u_clamp_col (
    .sum  (col_sum),
    .size (screen_columns),
    .pos  (col_clamped)
  );

  ps2c_clamp u_clamp_row (
    .sum  (row_sum),
    .size (screen_rows),
    .pos  (row_clamped)
  );

  // Packet bytes and cursor position
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= '0;
      x_move_byte <= '0;
      column_now  <= ps2c_pkg::RESET_COLUMN;
      row_now     <= ps2c_pkg::RESET_ROW;
    end else if (byte_take) begin
      if (byte_phase == ps2c_pkg::PH_HEADER) header_byte <= data_byte;
      if (byte_phase == ps2c_pkg::PH_XMOVE)  x_move_byte <= data_byte;
      if (packet_done) begin
        column_now <= col_clamped;
        row_now    <= row_clamped;
      end
    end
  end

  // Middle stage: new position and erase index
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (packet_done) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (packet_done) begin
      s1_col   <= col_clamped;
      s1_row   <= row_clamped;
      s1_erase <= cell_of(row_now, column_now, screen_columns);
    end
  end

  // Output register: draw index formed on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_valid <= 1'b0;
    end else if (s1_move) begin
      cursor_valid <= 1'b1;
    end else if (!cursor_stall) begin
      cursor_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      erase_cell <= s1_erase;
      draw_cell  <= cell_of(s1_row, s1_col, screen_columns);
      new_column <= s1_col;
      new_row    <= s1_row;
    end
  end

  // Checks
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_col) && $stable(s1_row))
    else $error("middle stage lost or changed a waiting result");

  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(cursor_valid) |-> $past(s1_valid))
    else $error("result appeared without a completed packet");

  a_third_byte: assert property (@(posedge clk) disable iff (rst)
    byte_take && byte_phase == ps2c_pkg::PH_YMOVE |=> s1_valid)
    else $error("third byte did not produce a result");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cursor_valid |-> (new_column < screen_columns || new_column == '0))
    else $error("cursor column beyond the screen");

endmodule

/* rtl/ps2c_clamp.sv */
// ps2c_clamp: clamps a signed moved coordinate to [0, size-1], size 0 acting as 1.
// Depends on ps2c_pkg.
module ps2c_clamp (
  input  logic signed [ps2c_pkg::SUM_W-1:0]   sum,
  input  logic        [ps2c_pkg::COORD_W-1:0] size,
  output logic        [ps2c_pkg::COORD_W-1:0] pos
);

  logic [ps2c_pkg::COORD_W-1:0] limit;

  // Largest legal coordinate
  assign limit = (size == '0) ? '0 : size - 1'b1;

  // Clamp below at zero, above at limit
  always_comb begin
    if (sum[ps2c_pkg::SUM_W-1]) begin
      pos = '0;
    end else if (sum > $signed({3'b000, limit})) begin
      pos = limit;
    end else begin
      pos = sum[ps2c_pkg::COORD_W-1:0];
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: self-checking bench for ps2_mouse_text_cursor, with a cursor tracker class
// that predicts each packet's erase/draw cells. Depends on ps2c_pkg and the block RTL.
module tb_top;
  import ps2c_pkg::*;

  // Spare register indexes, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_BYTES  = 150;

  typedef struct packed {
    logic [CELL_W-1:0]  erase;
    logic [CELL_W-1:0]  draw;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } cursor_move_t;

  // Tracks packet phase and cursor position, queues the expected cursor moves
  class cursor_tracker;
    logic [COORD_W-1:0] columns, rows, column, row, header, x_byte;
    phase_t phase;
    cursor_move_t moves_due[$];
    int errors;
    int moves_seen;

    function new();
      columns = RESET_COLUMNS;
      rows    = RESET_ROWS;
      column  = RESET_COLUMN;
      row     = RESET_ROW;
      header  = '0;
      x_byte  = '0;
      phase   = PH_HEADER;
      errors  = 0;
      moves_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      if (idx == CFG_COLUMNS) columns = val;
      else if (idx == CFG_ROWS) rows = val;
    endfunction

    function logic [CELL_W-1:0] cell_of(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
      logic [31:0] full;
      full = 32'(r) * 32'(columns) + 32'(c);
      return full[CELL_W-1:0];
    endfunction

    // Size 0 behaves like size 1: limit is 0
    function logic [COORD_W-1:0] clamp_coord(logic signed [SUM_W-1:0] v,
                                             logic [COORD_W-1:0] size);
      logic [COORD_W-1:0] lim;
      lim = (size == '0) ? '0 : size - 1'b1;
      if (v < 0) return '0;
      if (v > $signed({{(SUM_W-COORD_W){1'b0}}, lim})) return lim;
      return v[COORD_W-1:0];
    endfunction

    // Note one accepted byte; the third of a packet yields an expected move
    function void take_byte(logic [7:0] b);
      logic signed [SUM_W-1:0] dx, dy, next_c, next_r;
      cursor_move_t m;
      case (phase)
        PH_HEADER: begin
          header = b;
          phase  = PH_XMOVE;
        end
        PH_XMOVE: begin
          x_byte = b;
          phase  = PH_YMOVE;
        end
        default: begin
          phase  = PH_HEADER;
          dx     = {{(SUM_W-COORD_W){header[SIGN_X_POS]}}, x_byte};
          dy     = {{(SUM_W-COORD_W){header[SIGN_Y_POS]}}, b};
          next_c = $signed({{(SUM_W-COORD_W){1'b0}}, column}) + dx;
          next_r = $signed({{(SUM_W-COORD_W){1'b0}}, row}) - dy;
          // erase uses the old (possibly out-of-range) position
          m.erase = cell_of(row, column);
          column  = clamp_coord(next_c, columns);
          row     = clamp_coord(next_r, rows);
          m.draw  = cell_of(row, column);
          m.col   = column;
          m.row   = row;
          moves_due.push_back(m);
        end
      endcase
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("ERROR: %s", what);
    endfunction

    // Compare one accepted cursor transfer with the oldest expected move
    function void check_cursor(cursor_move_t got);
      cursor_move_t want;
      if (moves_due.size() == 0) begin
        flag($sformatf("unexpected cursor transfer erase=%0d draw=%0d col=%0d row=%0d",
                       got.erase, got.draw, got.col, got.row));
        return;
      end
      want = moves_due.pop_front();
      moves_seen++;
      if (got.erase !== want.erase || got.draw !== want.draw ||
          got.col !== want.col || got.row !== want.row)
        flag($sformatf("move %0d: exp erase=%0d draw=%0d col=%0d row=%0d, got %0d %0d %0d %0d",
                       moves_seen, want.erase, want.draw, want.col, want.row,
                       got.erase, got.draw, got.col, got.row));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;
  logic byte_valid = 1'b0;
  logic byte_stall;
  logic [7:0] data_byte = '0;
  logic cursor_valid;
  logic cursor_stall = 1'b0;
  logic [CELL_W-1:0] erase_cell, draw_cell;
  logic [COORD_W-1:0] new_column, new_row;

  cursor_tracker tracker = new();
  bit send_gaps = 1'b0;
  bit stall_gaps = 1'b0;
  bit hold_req = 1'b0;
  int bytes_sent = 0;
  int screen_settings = 0;

  ps2_mouse_text_cursor dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .data_byte(data_byte),
    .cursor_valid(cursor_valid), .cursor_stall(cursor_stall),
    .erase_cell(erase_cell), .draw_cell(draw_cell),
    .new_column(new_column), .new_row(new_row)
  );

  always #5 clk = ~clk;

  // Monitors: sample pre-edge values of both channels
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) tracker.take_byte(data_byte);
    if (!rst && cursor_valid && !cursor_stall)
      tracker.check_cursor(cursor_move_t'({erase_cell, draw_cell, new_column, new_row}));
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : cursor_receiver
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        cursor_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        cursor_stall <= 1'b0;
      end else if (stall_gaps && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        cursor_stall <= 1'b1;
        repeat (n) @(posedge clk);
        cursor_stall <= 1'b0;
      end
    end
  end

  // Offer one byte, with an optional idle burst first; returns at the transfer edge
  task automatic send_byte(input logic [7:0] b);
    int n;
    if (send_gaps && $urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 12);
      byte_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb, input logic [7:0] yb);
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
  endtask

  // Random packet: half small moves near the cursor, half full-range moves
  task automatic random_packet();
    logic [7:0] hdr;
    logic [8:0] mx, my;
    int sx, sy;
    hdr = 8'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      sx = int'($urandom_range(0, 16)) - 8;
      sy = int'($urandom_range(0, 16)) - 8;
      mx = sx[8:0];
      my = sy[8:0];
    end else begin
      mx = 9'($urandom);
      my = 9'($urandom);
    end
    hdr[SIGN_X_POS] = mx[8];
    hdr[SIGN_Y_POS] = my[8];
    send_packet(hdr, mx[7:0], my[7:0]);
  endtask

  // Drop valid, then wait until every expected move is out and the pipe drains
  task automatic wait_idle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (tracker.moves_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    tracker.write_reg(idx, val);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_screen(input logic [COORD_W-1:0] cols, input logic [COORD_W-1:0] rws);
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, rws);
    screen_settings++;
  endtask

  function automatic logic [COORD_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return 8'($urandom_range(2, 100));
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme moves on the reset 80x25 screen
    send_packet(8'h00, 8'h00, 8'h00);   // no move
    send_packet(8'h00, 8'hFF, 8'hFF);   // +255/+255: right edge, top row
    send_packet(8'h30, 8'h00, 8'h00);   // -256/-256: left edge, bottom row
    send_packet(8'hCF, 8'h80, 8'h7F);   // non-sign header bits set
    send_packet(8'hFF, 8'h80, 8'h80);   // -128/-128 with every header bit set
    send_packet(8'h10, 8'hFF, 8'h01);   // dx -1 at the left edge
    // Packet split across a register write
    send_byte(8'h08);
    wait_idle();
    // Zero screen size clamps to cell 0; spare indexes are ignored
    set_screen(8'd0, 8'd0);
    write_reg(CFG_SPARE_2, 8'hFF);
    write_reg(CFG_SPARE_3, 8'hFF);
    send_byte(8'h05);
    send_byte(8'h09);
    wait_idle();
    // Largest screen, push the cursor to the far corner
    set_screen(8'd255, 8'd255);
    send_packet(8'h20, 8'hFF, 8'h00);
    wait_idle();
    // Shrink under the cursor: erase from the old out-of-range spot
    set_screen(8'd10, 8'd5);
    send_packet(8'h00, 8'h00, 8'h00);

    // Random phases, each with its own screen size
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      case (p)
        0:       set_screen(8'd1, 8'd1);
        1:       set_screen(8'd255, 8'd255);
        2:       set_screen(RESET_COLUMNS, RESET_ROWS);
        default: set_screen(pick_size(), pick_size());
      endcase
      send_gaps  = (p < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      stall_gaps = (p < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (p == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        // Mostly whole packets, sometimes a stray byte to shift alignment
        if ($urandom_range(0, 11) == 0) begin
          send_byte(8'($urandom));
          sent += 1;
        end else begin
          random_packet();
          sent += 3;
        end
      end
    end

    // Drain
    byte_valid <= 1'b0;
    send_gaps  = 1'b0;
    stall_gaps = 1'b0;
    @(posedge clk);
    while (tracker.moves_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d mouse bytes, checked %0d cursor moves over %0d screen sizes,",
             bytes_sent, tracker.moves_seen, screen_settings);
    $display("including zero, one and 255 sized screens and a long output hold-off.");
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2000000;
    $display("Timeout waiting for the cursor channel");
    $display("Test completed with failures");
    $finish;
  end

endmodule
